[hdl/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared widths, codes, payload types and control structs of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    localparam int DEF_NUM_QUEUES = 5;
    localparam int DEF_MAX_PROCS  = 64;
    localparam int DEF_WAIT_BITS  = 16;

    localparam int ID_W   = 6;
    localparam int LVL_W  = 3;
    localparam int MODE_W = 3;
    localparam int ST_W   = 3;
    localparam int PROM_W = 7;
    localparam int AGE_W  = 16;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 9;

    localparam logic [AGE_W-1:0]  AGE_RESET = 16'd30;
    localparam logic [PROM_W-1:0] PROM_MAX  = 7'd127;

    localparam logic [MODE_W-1:0] MODE_ENQ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REM   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCHED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RET   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   proc_id;
        logic [LVL_W-1:0]  queue_level;
        logic              demote;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]   chosen_id;
        logic [LVL_W-1:0]  chosen_level;
        logic [ST_W-1:0]   status;
        logic [PROM_W-1:0] promoted_count;
    } t_result;

    typedef struct packed {
        logic             del;
        logic             app;
        logic [POS_W-1:0] pos;
        logic [ID_W-1:0]  data;
    } t_row_cmd;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic [ID_W-1:0]  head;
        logic [LEN_W-1:0] len;
    } t_row_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_RD,
        S_TICK_WR,
        S_AGE_LVL,
        S_AGE_RD,
        S_AGE_EX,
        S_POP_RD,
        S_POP_EX
    } t_state;

endpackage

`default_nettype wire

[hdl/mlfq_scheduler_with_aging.sv]
// ----------------------------------------------------------------------------
// MLFQ scheduler with aging
// Priority queues of process ids built as rows of cells, with per-process
// wait counters and levels held in a small memory, run by a sequencer.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. Its single result
// appears on o_result for one cycle with o_done high; the receiver cannot
// stall it. Configuration (max_age) is written through i_cfg_we/i_cfg_wdata
// only while the block is idle; the user must keep to this, since the
// block does not enforce it. Work per item, up to the result strobe:
//   enqueue, remove, return: a counter read, then the queue update;
//   unused modes: a zero result straight from idle.
//   tick: per slot, a counter read and, if queued and unsaturated, a write.
//   schedule: one counter read per entry in levels 1 and up, through the
//   single read port of the counter memory, then the pop of the head.
// The next item may start in the cycle the result is shown.
// Reset empties every queue, clears all wait counters and levels through
// valid bits, and loads max_age with 30; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_scheduler_with_aging import mlfq_pkg::*; #(
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    parameter int MAX_PROCS  = DEF_MAX_PROCS,
    parameter int WAIT_BITS  = DEF_WAIT_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_item            i_item,
    output logic                  o_done,
    output t_result               o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [AGE_W-1:0] i_cfg_wdata
);

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int AW = $clog2(MAX_PROCS);
    localparam int LW = $clog2(MAX_PROCS + 1);
    localparam int EW = LVL_W + WAIT_BITS;
    localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    t_result           r_res, n_res;
    logic              r_done, n_done;
    logic [QW-1:0]     r_q, n_q;
    logic [LW-1:0]     r_n, n_n;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic [PROM_W-1:0] r_prom, n_prom;
    logic [AGE_W-1:0]  r_max_age;

    logic [EW-1:0]        r_mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_vld;
    logic [EW-1:0]        r_rd_data;
    logic                 r_rd_vld;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [EW-1:0]        mem_wd;
    logic [AW-1:0]        mem_ra;
    logic [LVL_W-1:0]     ent_lvl;
    logic [WAIT_BITS-1:0] ent_wait;

    t_row_cmd        cmd  [NUM_QUEUES];
    t_row_stat       stat [NUM_QUEUES];
    logic [ID_W-1:0] qid;
    logic            any_hit;
    logic            ne_found;
    logic [QW-1:0]   ne_q;
    logic [QW-1:0]   c_q;
    logic [QW-1:0]   c_qm1;
    logic [ID_W-1:0] c_s;

    for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_row
        mlfq_row #(.MAX_PROCS(MAX_PROCS)) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[g]),
            .i_qid   (qid),
            .o_stat  (stat[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            r_rd_vld <= r_vld[mem_ra];
        end
    end

    assign ent_lvl  = r_rd_vld ? r_rd_data[EW-1 -: LVL_W] : '0;
    assign ent_wait = r_rd_vld ? r_rd_data[WAIT_BITS-1:0] : '0;

    always_comb begin
        any_hit  = 1'b0;
        ne_found = 1'b0;
        ne_q     = '0;
        for (int k = 0; k < NUM_QUEUES; k++) begin
            any_hit = any_hit | stat[k].hit;
        end
        for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
            if (stat[k].len != '0) begin
                ne_found = 1'b1;
                ne_q     = QW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_max_age <= AGE_RESET;
            r_q       <= '0;
            r_n       <= '0;
            r_cnt     <= '0;
            r_prom    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_q     <= n_q;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
            r_prom  <= n_prom;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_res   = r_res;
        n_done  = 1'b0;
        n_q     = r_q;
        n_n     = r_n;
        n_cnt   = r_cnt;
        n_prom  = r_prom;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = '0;
        mem_ra  = '0;
        qid     = '0;
        c_q     = '0;
        c_qm1   = '0;
        c_s     = '0;
        for (int k = 0; k < NUM_QUEUES; k++) begin
            cmd[k] = '0;
        end

        case (r_state)
            S_IDLE: begin
                mem_ra = AW'(i_item.proc_id);
                if (start) begin
                    n_item = i_item;
                    n_prom = '0;
                    case (i_item.mode)
                        MODE_ENQ, MODE_REM, MODE_RET: begin
                            n_state = S_EXEC;
                        end
                        MODE_TICK: begin
                            n_cnt   = '0;
                            n_state = S_TICK_RD;
                        end
                        MODE_SCHED: begin
                            n_q     = QW'(1);
                            n_state = S_AGE_LVL;
                        end
                        default: begin
                            n_res  = '0;
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_EXEC: begin
                qid     = r_item.proc_id;
                n_done  = 1'b1;
                n_state = S_IDLE;
                n_res   = '0;
                n_res.chosen_id = r_item.proc_id;
                if (32'(r_item.proc_id) >= 32'(MAX_PROCS)) begin
                    n_res.status = ST_NOTFOUND;
                end else begin
                    case (r_item.mode)
                        MODE_ENQ: begin
                            if (32'(r_item.queue_level) >= 32'(NUM_QUEUES)) begin
                                c_q = QW'(NUM_QUEUES - 1);
                            end else begin
                                c_q = QW'(r_item.queue_level);
                            end
                        end
                        MODE_REM: begin
                            c_q = QW'(ent_lvl);
                        end
                        default: begin
                            c_q = QW'(ent_lvl);
                            if (r_item.demote && (32'(c_q) + 1 < NUM_QUEUES)) begin
                                c_q = c_q + 1'b1;
                            end
                        end
                    endcase
                    n_res.chosen_level = LVL_W'(c_q);
                    if (r_item.mode == MODE_REM) begin
                        if (stat[c_q].hit) begin
                            cmd[c_q].del = 1'b1;
                            cmd[c_q].pos = stat[c_q].pos;
                        end else begin
                            n_res.status = ST_NOTFOUND;
                        end
                    end else if (stat[c_q].hit) begin
                        n_res.status = ST_DUP;
                    end else if (32'(stat[c_q].len) >= 32'(MAX_PROCS)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        cmd[c_q].app  = 1'b1;
                        cmd[c_q].data = r_item.proc_id;
                        mem_we = 1'b1;
                        mem_wa = AW'(r_item.proc_id);
                        mem_wd = {LVL_W'(c_q), {WAIT_BITS{1'b0}}};
                    end
                end
            end

            S_TICK_RD: begin
                mem_ra  = r_cnt;
                n_state = S_TICK_WR;
            end

            S_TICK_WR: begin
                qid = ID_W'(r_cnt);
                if (any_hit && (32'(r_cnt) < (1 << ID_W)) && (ent_wait != WAIT_MAX)) begin
                    mem_we = 1'b1;
                    mem_wa = r_cnt;
                    mem_wd = {ent_lvl, ent_wait + 1'b1};
                end
                if (32'(r_cnt) == MAX_PROCS - 1) begin
                    n_res   = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_TICK_RD;
                end
            end

            S_AGE_LVL: begin
                if (stat[r_q].len == '0) begin
                    if (32'(r_q) == NUM_QUEUES - 1) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_q = r_q + 1'b1;
                    end
                end else begin
                    n_n     = LW'(stat[r_q].len);
                    n_state = S_AGE_RD;
                end
            end

            S_AGE_RD: begin
                mem_ra  = AW'(stat[r_q].head);
                n_state = S_AGE_EX;
            end

            S_AGE_EX: begin
                c_s   = stat[r_q].head;
                c_qm1 = r_q - 1'b1;
                qid   = c_s;
                cmd[r_q].del = 1'b1;
                if ((32'(ent_wait) > 32'(r_max_age))
                    && (stat[c_qm1].hit || (32'(stat[c_qm1].len) < 32'(MAX_PROCS)))) begin
                    if (!stat[c_qm1].hit) begin
                        cmd[c_qm1].app  = 1'b1;
                        cmd[c_qm1].data = c_s;
                        mem_we = 1'b1;
                        mem_wa = AW'(c_s);
                        mem_wd = {LVL_W'(c_qm1), {WAIT_BITS{1'b0}}};
                    end
                    if (r_prom != PROM_MAX) begin
                        n_prom = r_prom + 1'b1;
                    end
                end else begin
                    cmd[r_q].app  = 1'b1;
                    cmd[r_q].data = c_s;
                end
                n_n = r_n - 1'b1;
                if (r_n == LW'(1)) begin
                    if (32'(r_q) == NUM_QUEUES - 1) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_q     = r_q + 1'b1;
                        n_state = S_AGE_LVL;
                    end
                end else begin
                    n_state = S_AGE_RD;
                end
            end

            S_POP_RD: begin
                if (!ne_found) begin
                    n_res = '0;
                    n_res.status         = ST_EMPTY;
                    n_res.promoted_count = r_prom;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_q     = ne_q;
                    mem_ra  = AW'(stat[ne_q].head);
                    n_state = S_POP_EX;
                end
            end

            S_POP_EX: begin
                c_s = stat[r_q].head;
                cmd[r_q].del = 1'b1;
                mem_we = 1'b1;
                mem_wa = AW'(c_s);
                mem_wd = {ent_lvl, {WAIT_BITS{1'b0}}};
                n_res.chosen_id      = c_s;
                n_res.chosen_level   = LVL_W'(r_q);
                n_res.status         = ST_OK;
                n_res.promoted_count = r_prom;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

[hdl/mlfq_cell.sv]
// ----------------------------------------------------------------------------
// MLFQ queue cell
// One queue entry: loads a new id, takes its neighbor's id on a shift, and
// compares its id against the broadcast query id.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_cell import mlfq_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_load,
    input  wire logic            i_shift,
    input  wire logic [ID_W-1:0] i_load_data,
    input  wire logic [ID_W-1:0] i_nb_data,
    input  wire logic            i_valid,
    input  wire logic [ID_W-1:0] i_qid,
    output logic      [ID_W-1:0] o_val,
    output logic                 o_match
);

    logic [ID_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_load_data;
        end else if (i_shift) begin
            r_val <= i_nb_data;
        end
    end

    assign o_val   = r_val;
    assign o_match = i_valid && (r_val == i_qid);

endmodule

`default_nettype wire

[hdl/mlfq_row.sv]
// ----------------------------------------------------------------------------
// MLFQ queue row
// One priority level as a chain of cells with a length register. Supports a
// delete with gap closing and a tail append in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_row import mlfq_pkg::*; #(
    parameter int MAX_PROCS = DEF_MAX_PROCS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_row_cmd        i_cmd,
    input  wire logic [ID_W-1:0] i_qid,
    output t_row_stat            o_stat
);

    localparam int PW = $clog2(MAX_PROCS);
    localparam int LW = $clog2(MAX_PROCS + 1);

    logic [LW-1:0]        r_len;
    logic [LW-1:0]        wpos;
    logic [ID_W-1:0]      val [MAX_PROCS];
    logic [MAX_PROCS-1:0] match;
    logic [PW-1:0]        hit_pos;

    assign wpos = r_len - LW'(i_cmd.del);

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        logic [ID_W-1:0] nb;
        if (i == MAX_PROCS - 1) begin : g_last
            assign nb = val[i];
        end else begin : g_mid
            assign nb = val[i+1];
        end
        mlfq_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (i_cmd.app && (wpos == LW'(i))),
            .i_shift     (i_cmd.del && (PW'(i) >= i_cmd.pos[PW-1:0])),
            .i_load_data (i_cmd.data),
            .i_nb_data   (nb),
            .i_valid     (LW'(i) < r_len),
            .i_qid       (i_qid),
            .o_val       (val[i]),
            .o_match     (match[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= r_len + LW'(i_cmd.app) - LW'(i_cmd.del);
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int k = 0; k < MAX_PROCS; k++) begin
            if (match[k]) begin
                hit_pos = hit_pos | PW'(k);
            end
        end
    end

    assign o_stat.hit  = |match;
    assign o_stat.pos  = POS_W'(hit_pos);
    assign o_stat.head = val[0];
    assign o_stat.len  = LEN_W'(r_len);

endmodule

`default_nettype wire
